// ===== sv/etok_pkg.sv =====
// Shared types and character constants for the expression tokenizer.
`default_nettype none
package etok_pkg;

  localparam int unsigned OUT_W = 16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  typedef enum logic [4:0] {
    K_NUM     = 5'd0,
    K_IDENT   = 5'd1,
    K_EXP     = 5'd2,
    K_PLUS    = 5'd3,
    K_MINUS   = 5'd4,
    K_MUL     = 5'd5,
    K_DIV     = 5'd6,
    K_MOD     = 5'd7,
    K_POW     = 5'd8,
    K_LPAR    = 5'd9,
    K_RPAR    = 5'd10,
    K_LBRK    = 5'd11,
    K_RBRK    = 5'd12,
    K_LBRC    = 5'd13,
    K_RBRC    = 5'd14,
    K_INVALID = 5'd15,
    K_END     = 5'd16
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] length;
    logic             last;
  } etok_result_t;

  typedef struct packed {
    logic [1:0]   count;
    etok_result_t first;
    etok_result_t second;
  } etok_push_t;

endpackage
`default_nettype wire

// ===== sv/etok_lexer.sv =====
// Input stage, lexer state machine and token result generation.
`default_nettype none
module etok_lexer
  import etok_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       in_op_i,
  input  wire logic [7:0] in_char_i,
  input  wire logic       room_i,
  output etok_push_t      push_o
);

  typedef enum logic [16:0] {
    S_START = 17'h00001,
    S_NUM   = 17'h00002,
    S_DEC   = 17'h00004,
    S_IDENT = 17'h00008,
    S_PLUS  = 17'h00010,
    S_MINUS = 17'h00020,
    S_MUL   = 17'h00040,
    S_DIV   = 17'h00080,
    S_MOD   = 17'h00100,
    S_POW   = 17'h00200,
    S_EXP   = 17'h00400,
    S_LPAR  = 17'h00800,
    S_RPAR  = 17'h01000,
    S_LBRK  = 17'h02000,
    S_RBRK  = 17'h04000,
    S_LBRC  = 17'h08000,
    S_RBRC  = 17'h10000
  } lex_e;

  localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic can_start(input logic [7:0] c);
    logic ok;
    ok = is_digit(c) || is_letter(c);
    case (c)
      CH_DOT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET,
      CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC: ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

  function automatic lex_e start_state(input logic [7:0] c, input logic after_num);
    lex_e ns;
    ns = S_START;
    if (is_digit(c)) begin
      ns = S_NUM;
    end else if (is_letter(c)) begin
      ns = (after_num && ((c == CH_LO_E) || (c == CH_UP_E))) ? S_EXP : S_IDENT;
    end else begin
      case (c)
        CH_DOT:   ns = S_DEC;
        CH_PLUS:  ns = S_PLUS;
        CH_MINUS: ns = S_MINUS;
        CH_STAR:  ns = S_MUL;
        CH_SLASH: ns = S_DIV;
        CH_PCT:   ns = S_MOD;
        CH_CARET: ns = S_POW;
        CH_LPAR:  ns = S_LPAR;
        CH_RPAR:  ns = S_RPAR;
        CH_LBRK:  ns = S_LBRK;
        CH_RBRK:  ns = S_RBRK;
        CH_LBRC:  ns = S_LBRC;
        CH_RBRC:  ns = S_RBRC;
        default:  ns = S_START;
      endcase
    end
    return ns;
  endfunction

  function automatic kind_e kind_of(input lex_e s);
    kind_e k;
    unique case (s)
      S_IDENT: k = K_IDENT;
      S_EXP:   k = K_EXP;
      S_PLUS:  k = K_PLUS;
      S_MINUS: k = K_MINUS;
      S_MUL:   k = K_MUL;
      S_DIV:   k = K_DIV;
      S_MOD:   k = K_MOD;
      S_POW:   k = K_POW;
      S_LPAR:  k = K_LPAR;
      S_RPAR:  k = K_RPAR;
      S_LBRK:  k = K_LBRK;
      S_RBRK:  k = K_RBRK;
      S_LBRC:  k = K_LBRC;
      S_RBRC:  k = K_RBRC;
      default: k = K_NUM;
    endcase
    return k;
  endfunction

  logic                stg_valid_q;
  logic                stg_op_q;
  logic [7:0]          stg_char_q;
  lex_e                state_q, state_d;
  logic [POS_BITS-1:0] begin_q, begin_d;
  logic [POS_BITS-1:0] len_q, len_d;
  logic [POS_BITS-1:0] pos_q, pos_d;

  logic                proc;
  logic                extend, cut, after_num, invalid;
  lex_e                nxt;
  kind_e               cut_kind;
  logic [POS_BITS+OUT_W-1:0] begin_ext, len_ext, pos_ext;
  logic [OUT_W-1:0]    len_sat;
  etok_result_t        tok_res, inv_res, end_res;
  etok_push_t          push;

  assign proc       = stg_valid_q && room_i;
  assign in_ready_o = !stg_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stg_op_q   <= in_op_i;
      stg_char_q <= in_char_i;
    end
  end

  assign begin_ext = {{OUT_W{1'b0}}, begin_q};
  assign len_ext   = {{OUT_W{1'b0}}, len_q};
  assign pos_ext   = {{OUT_W{1'b0}}, pos_q};
  assign len_sat   = (|len_ext[POS_BITS+OUT_W-1:OUT_W]) ? {OUT_W{1'b1}} : len_ext[OUT_W-1:0];

  always_comb begin
    extend    = 1'b0;
    cut       = 1'b0;
    after_num = 1'b0;
    nxt       = state_q;
    cut_kind  = kind_of(state_q);
    unique case (state_q)
      S_START: ;
      S_NUM: begin
        if (is_digit(stg_char_q)) begin
          extend = 1'b1;
        end else if (stg_char_q == CH_DOT) begin
          extend = 1'b1;
          nxt    = S_DEC;
        end else begin
          cut       = 1'b1;
          cut_kind  = K_NUM;
          after_num = 1'b1;
        end
      end
      S_DEC: begin
        if (is_digit(stg_char_q)) begin
          extend = 1'b1;
        end else begin
          cut       = 1'b1;
          cut_kind  = K_NUM;
          after_num = 1'b1;
        end
      end
      S_IDENT: begin
        if (is_digit(stg_char_q) || is_letter(stg_char_q)) begin
          extend = 1'b1;
        end else begin
          cut      = 1'b1;
          cut_kind = K_IDENT;
        end
      end
      S_MUL: begin
        if (stg_char_q == CH_STAR) begin
          extend = 1'b1;
          nxt    = S_POW;
        end else begin
          cut      = 1'b1;
          cut_kind = K_MUL;
        end
      end
      S_EXP: begin
        if (is_letter(stg_char_q)) begin
          extend = 1'b1;
          nxt    = S_IDENT;
        end else begin
          cut = 1'b1;
          case (stg_char_q)
            CH_SPACE, CH_SLASH, CH_PCT, CH_STAR, CH_CARET,
            CH_RPAR, CH_RBRK, CH_RBRC: cut_kind = K_IDENT;
            default:                   cut_kind = K_EXP;
          endcase
        end
      end
      default: begin
        cut = 1'b1;
      end
    endcase
  end

  assign invalid = (stg_char_q != CH_SPACE) && !can_start(stg_char_q);

  always_comb begin
    tok_res.kind   = cut_kind;
    tok_res.start  = begin_ext[OUT_W-1:0];
    tok_res.length = len_sat;
    tok_res.last   = 1'b0;
    inv_res.kind   = K_INVALID;
    inv_res.start  = pos_ext[OUT_W-1:0];
    inv_res.length = {{(OUT_W-1){1'b0}}, 1'b1};
    inv_res.last   = 1'b1;
    end_res.kind   = K_END;
    end_res.start  = '0;
    end_res.length = '0;
    end_res.last   = 1'b1;

    push.count  = 2'd0;
    push.first  = end_res;
    push.second = end_res;
    if (stg_op_q) begin
      if (state_q != S_START) begin
        tok_res.kind = (state_q == S_EXP) ? K_IDENT : kind_of(state_q);
        push.first   = tok_res;
        push.count   = 2'd2;
      end else begin
        push.count = 2'd1;
      end
    end else if (!extend) begin
      if (cut && invalid) begin
        push.first  = tok_res;
        push.second = inv_res;
        push.count  = 2'd2;
      end else if (cut) begin
        tok_res.last = 1'b1;
        push.first   = tok_res;
        push.count   = 2'd1;
      end else if (invalid) begin
        push.first = inv_res;
        push.count = 2'd1;
      end
    end
    if (!proc) begin
      push.count = 2'd0;
    end
  end

  assign push_o = push;

  always_comb begin
    state_d = state_q;
    begin_d = begin_q;
    len_d   = len_q;
    pos_d   = pos_q;
    if (proc) begin
      if (stg_op_q) begin
        state_d = S_START;
        len_d   = '0;
      end else begin
        pos_d = pos_q + POS_ONE;
        if (extend) begin
          state_d = nxt;
          if (len_q != POS_MAX) begin
            len_d = len_q + POS_ONE;
          end
        end else if ((stg_char_q == CH_SPACE) || invalid) begin
          state_d = S_START;
          len_d   = '0;
        end else begin
          state_d = start_state(stg_char_q, after_num);
          begin_d = pos_q;
          len_d   = POS_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_START;
      begin_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      begin_q <= begin_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/etok_result_fifo.sv =====
// Four-entry result queue: takes up to two results per cycle, hands out one per cycle while the reader is ready.
`default_nettype none
module etok_result_fifo
  import etok_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire etok_push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output etok_result_t      out_res_o
);

  etok_result_t mem_q [4];
  logic [1:0]   wr_ptr_q, wr_ptr_d;
  logic [1:0]   rd_ptr_q, rd_ptr_d;
  logic [2:0]   cnt_q, cnt_d;
  logic         pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign room_o      = (cnt_q <= 3'd2);
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.count;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    cnt_d    = cnt_q + {1'b0, push_i.count} - {2'b00, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/expression_tokenizer_unit.sv =====
// Top level of the expression tokenizer: character stream in, token stream out.
//
// Usage:
//   Slave side carries one request per character (tuser = 0, tdata = byte) or an
//   end-of-input request (tuser = 1) that flushes the pending token and adds an
//   end token. Master side carries tokens: tuser = kind, tdata = start position
//   (low half) and lexeme length (high half), tlast on the final token that one
//   request produced. Requests that only grow a token produce nothing.
//   A request is first held in the input stage register, then lexed into the
//   result queue, from which its first token shows on the master side.
//   Throughput: one request per cycle while the queue has room; a two-token
//   request needs an extra output transfer, which backs up into tready through
//   a four-entry queue (a request is lexed only while two entries are free).
//   Reset clears the lexer to its start state, position and length to zero and
//   empties the queue. When the receiver stalls, tokens wait in the queue and
//   the input stage holds one request; then tready drops.
`default_nettype none
module expression_tokenizer_unit
  import etok_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic [0:0]  s_axis_tuser,   // [0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] lexeme_start, [31:16] lexeme_length
  output logic [4:0]       m_axis_tuser,   // [4:0] token_kind
  output logic             m_axis_tlast    // last_of_run
);

  etok_push_t   push;
  logic         room;
  etok_result_t res;

  etok_lexer #(
    .POS_BITS(POS_BITS)
  ) u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser[0]),
    .in_char_i  (s_axis_tdata),
    .room_i     (room),
    .push_o     (push)
  );

  etok_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {res.length, res.start};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire
